// File: rtl/core/cas_pkg.sv
// Package for the augmented CRC block: widths, register indices, reset
// values and the configuration and item structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

  localparam int unsigned CrcW    = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegWidthMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPolyValue = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPadEnable = 2'd2;
  localparam logic [CfgIdxW-1:0] RegInitValue = 2'd3;

  localparam logic [CrcW-1:0] Top16     = 16'h8000;
  localparam logic [CrcW-1:0] Top8      = 16'h0080;
  localparam logic [CrcW-1:0] Mask16    = 16'hFFFF;
  localparam logic [CrcW-1:0] Mask8     = 16'h00FF;
  localparam logic [CrcW-1:0] PolyReset = 16'h1021;
  localparam logic [CrcW-1:0] InitReset = 16'h0000;

  typedef struct packed {
    logic            wide;
    logic [CrcW-1:0] poly;
    logic            pad;
    logic [CrcW-1:0] init;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             present;
    logic             first;
    logic             last;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/core/cas_byte_shift.sv
// Eight augmented CRC bit steps for one byte, MSB first, 8- or 16-bit mode.
// Depends on cas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cas_byte_shift (
  input  wire logic                       wide_i,
  input  wire logic [cas_pkg::CrcW-1:0]   poly_i,
  input  wire logic [cas_pkg::CrcW-1:0]   crc_i,
  input  wire logic [cas_pkg::ByteW-1:0]  byte_i,
  output logic      [cas_pkg::CrcW-1:0]   crc_o
);

  logic [cas_pkg::CrcW-1:0] mask;
  logic [cas_pkg::CrcW-1:0] top;
  logic [cas_pkg::CrcW-1:0] poly_m;

  assign mask   = wide_i ? cas_pkg::Mask16 : cas_pkg::Mask8;
  assign top    = wide_i ? cas_pkg::Top16 : cas_pkg::Top8;
  assign poly_m = poly_i & mask;

  always_comb begin
    logic [cas_pkg::CrcW-1:0] r;
    logic                     fb;
    r = crc_i;
    for (int k = cas_pkg::ByteW - 1; k >= 0; k--) begin
      fb = |(r & top);
      r  = {r[cas_pkg::CrcW-2:0], byte_i[k]} & mask;
      if (fb) begin
        r = r ^ poly_m;
      end
    end
    crc_o = r;
  end

endmodule

`default_nettype wire

// File: rtl/core/cas_update.sv
// Next CRC register for one item: init load, data byte, then zero padding.
// Depends on cas_pkg and cas_byte_shift.
`timescale 1ns / 1ps
`default_nettype none

module cas_update (
  input  wire cas_pkg::cfg_t             cfg_i,
  input  wire cas_pkg::item_t            item_i,
  input  wire logic [cas_pkg::CrcW-1:0]  crc_i,
  output logic      [cas_pkg::CrcW-1:0]  crc_o
);

  logic [cas_pkg::CrcW-1:0] mask;
  logic [cas_pkg::CrcW-1:0] base;
  logic [cas_pkg::CrcW-1:0] data_shift;
  logic [cas_pkg::CrcW-1:0] after_data;
  logic [cas_pkg::CrcW-1:0] pad1;
  logic [cas_pkg::CrcW-1:0] pad2;
  logic [cas_pkg::CrcW-1:0] padded;

  assign mask = cfg_i.wide ? cas_pkg::Mask16 : cas_pkg::Mask8;
  assign base = (item_i.first ? cfg_i.init : crc_i) & mask;

  cas_byte_shift u_data (
    .wide_i (cfg_i.wide),
    .poly_i (cfg_i.poly),
    .crc_i  (base),
    .byte_i (item_i.data),
    .crc_o  (data_shift)
  );

  assign after_data = item_i.present ? data_shift : base;

  cas_byte_shift u_pad1 (
    .wide_i (cfg_i.wide),
    .poly_i (cfg_i.poly),
    .crc_i  (after_data),
    .byte_i ('0),
    .crc_o  (pad1)
  );

  cas_byte_shift u_pad2 (
    .wide_i (cfg_i.wide),
    .poly_i (cfg_i.poly),
    .crc_i  (pad1),
    .byte_i ('0),
    .crc_o  (pad2)
  );

  // two zero bytes in 16-bit mode, one in 8-bit mode
  assign padded = cfg_i.wide ? pad2 : pad1;
  assign crc_o  = (item_i.last && cfg_i.pad) ? padded : after_data;

endmodule

`default_nettype wire

// File: rtl/core/crc_augmented_shift_8_16.sv
// Augmented bitwise CRC, 8/16-bit, MSB first, programmable polynomial.
// An accepted item passes the input register, then the result register, before it is valid.
// Throughput: one item per cycle unless the output stalls; crc_q feeds back combinationally.
// Reset: asynchronous, active low; registers return to 16-bit mode, poly 0x1021,
// padding on, init 0; CRC register cleared; both stages empty.
// Depends on cas_pkg and cas_update.
`timescale 1ns / 1ps
`default_nettype none

module crc_augmented_shift_8_16 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cas_pkg::CrcW-1:0]      cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [cas_pkg::ByteW-1:0]     data_byte_i,
  input  wire logic                          byte_present_i,
  input  wire logic                          first_item_i,
  input  wire logic                          last_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [cas_pkg::CrcW-1:0]      crc_value_o,
  output logic                               final_flag_o
);

  cas_pkg::cfg_t            cfg_q;
  cas_pkg::item_t           item_q;
  logic                     item_valid_q;
  logic                     out_valid_q;
  logic                     final_q;
  logic [cas_pkg::CrcW-1:0] crc_q;
  logic [cas_pkg::CrcW-1:0] crc_d;
  logic                     advance;
  logic                     in_accept;

  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide <= 1'b1;
      cfg_q.poly <= cas_pkg::PolyReset;
      cfg_q.pad  <= 1'b1;
      cfg_q.init <= cas_pkg::InitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cas_pkg::RegWidthMode: cfg_q.wide <= cfg_data_i[0];
        cas_pkg::RegPolyValue: cfg_q.poly <= cfg_data_i;
        cas_pkg::RegPadEnable: cfg_q.pad  <= cfg_data_i[0];
        cas_pkg::RegInitValue: cfg_q.init <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.data    <= data_byte_i;
      item_q.present <= byte_present_i;
      item_q.first   <= first_item_i;
      item_q.last    <= last_item_i;
    end
  end

  cas_update u_update (
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .crc_i  (crc_q),
    .crc_o  (crc_d)
  );

  // the CRC register doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        crc_q       <= crc_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      final_q <= item_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign crc_value_o  = crc_q;
  assign final_flag_o = final_q;

endmodule

`default_nettype wire

// File: rtl/core/cas_checker.sv
// Port-level checks for the augmented CRC block, bound to the top level.
// Depends on cas_pkg and crc_augmented_shift_8_16.
`timescale 1ns / 1ps
`default_nettype none

module cas_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cas_pkg::CrcW-1:0]      cfg_data_i,
  input  wire logic                          in_ready_o,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire logic [cas_pkg::CrcW-1:0]      crc_value_o,
  input  wire logic                          final_flag_o
);

  logic wide_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (cfg_we_i && (cfg_idx_i == cas_pkg::RegWidthMode)) begin
      wide_q <= cfg_data_i[0];
    end
  end

  // a result waiting on the consumer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(crc_value_o)
      && $stable(final_flag_o))
    else $error("result changed while stalled");

  // input only back-pressures when both stages are full and the output is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // 8-bit mode leaves the upper byte clear
  a_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !wide_q |-> crc_value_o[15:8] == 8'h00)
    else $error("upper CRC byte set in 8-bit mode");

endmodule

bind crc_augmented_shift_8_16 cas_checker u_cas_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .crc_value_o  (crc_value_o),
  .final_flag_o (final_flag_o)
);

`default_nettype wire
